>>> design/rpic_pkg.sv
// Shared types, register codes and arbiter tables of the interrupt controller.
`default_nettype none

package rpic_pkg;

  localparam int NUM_SRC   = 32;
  localparam int NUM_SUB   = 11;
  localparam int NUM_ARB   = 7;
  localparam int NUM_LEAF  = 6;
  localparam int NUM_SLOT  = 6;
  localparam int NUM_GROUP = 4;
  localparam int NUM_EVAL  = NUM_GROUP + 1;

  typedef enum logic [2:0] {
    OP_READ    = 3'd0,
    OP_WRITE   = 3'd1,
    OP_SRC_SET = 3'd2,
    OP_SRC_CLR = 3'd3,
    OP_SUB_SET = 3'd4,
    OP_SUB_CLR = 3'd5
  } op_e;

  typedef enum logic [3:0] {
    REG_SRC_PEND   = 4'd0,
    REG_FAST_MODE  = 4'd1,
    REG_SRC_MASK   = 4'd2,
    REG_PRIORITY   = 4'd3,
    REG_SVC_PEND   = 4'd4,
    REG_SVC_OFFSET = 4'd5,
    REG_SUB_PEND   = 4'd6,
    REG_SUB_MASK   = 4'd7
  } reg_e;

  typedef struct packed {
    logic [2:0]  op;
    logic [3:0]  reg_index;
    logic [31:0] write_data;
    logic [4:0]  source;
    logic        level;
  } item_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        irq_request;
    logic        fiq_request;
  } result_t;

  typedef logic [NUM_ARB-1:0][1:0] rot_t;

  typedef struct packed {
    logic [4:0] offset;
    rot_t       rotation;
  } arb_result_t;

  typedef struct packed {
    logic       found;
    logic [2:0] slot;
  } pick_t;

  // Reserved sources never reach the fast line and are always masked.
  localparam logic [31:0] FAST_MODE_WMASK = 32'hfeffffbf;
  localparam logic [31:0] MASK_FORCE      = 32'h01000040;

  localparam logic [4:0] ARB_MEMBER [NUM_LEAF][NUM_SLOT] = '{
    '{5'd0,  5'd0,  5'd1,  5'd2,  5'd3,  5'd0},
    '{5'd4,  5'd5,  5'd0,  5'd7,  5'd8,  5'd9},
    '{5'd10, 5'd11, 5'd12, 5'd13, 5'd14, 5'd15},
    '{5'd16, 5'd17, 5'd18, 5'd19, 5'd20, 5'd21},
    '{5'd22, 5'd23, 5'd0,  5'd25, 5'd26, 5'd27},
    '{5'd0,  5'd28, 5'd29, 5'd30, 5'd31, 5'd0}
  };

  localparam logic [NUM_SLOT-1:0] ARB_VALID [NUM_LEAF] = '{
    6'h1e, 6'h3b, 6'h3f, 6'h3f, 6'h3b, 6'h1e
  };

  localparam logic [2:0] ARB_ORDER [4][NUM_SLOT] = '{
    '{3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5},
    '{3'd0, 3'd2, 3'd3, 3'd4, 3'd1, 3'd5},
    '{3'd0, 3'd3, 3'd4, 3'd1, 3'd2, 3'd5},
    '{3'd0, 3'd4, 3'd1, 3'd2, 3'd3, 3'd5}
  };

  // Sub-source groups and the source each one drives, in evaluation order.
  localparam logic [NUM_SUB-1:0] SUB_GROUP [NUM_GROUP] = '{
    11'h007, 11'h038, 11'h1c0, 11'h600
  };
  localparam logic [4:0] GROUP_SRC [NUM_GROUP] = '{5'd28, 5'd23, 5'd15, 5'd31};

  // Scan the slots in rotated order and take the first request.
  function automatic pick_t arb_pick(input logic [1:0] rot, input logic [NUM_SLOT-1:0] req);
    pick_t      pick;
    logic [2:0] slot;
    pick = '0;
    for (int i = 0; i < NUM_SLOT; i++) begin
      slot = ARB_ORDER[rot][i];
      if (!pick.found && req[slot]) begin
        pick.found = 1'b1;
        pick.slot  = slot;
      end
    end
    return pick;
  endfunction

endpackage

`default_nettype wire

>>> design/rpic_if.sv
// Valid/ready channel interfaces for request items and result items.
`default_nettype none

interface rpic_in_if import rpic_pkg::*; ();
  logic  valid;
  logic  ready;
  item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rpic_out_if import rpic_pkg::*; ();
  logic    valid;
  logic    ready;
  result_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> design/rpic_arb_tree.sv
// Two-level rotating priority arbiter: six leaf arbiters feeding one root arbiter.
`default_nettype none

module rpic_arb_tree import rpic_pkg::*; (
  input  logic [NUM_SRC-1:0] service_i,
  input  rot_t               rot_i,
  input  logic [NUM_ARB-1:0] rot_en_i,
  output arb_result_t        result_o
);

  logic [NUM_LEAF-1:0][NUM_SLOT-1:0] leaf_req;
  pick_t                             leaf_pick [NUM_LEAF];
  logic [NUM_LEAF-1:0]               leaf_found;
  logic [4:0]                        leaf_win [NUM_LEAF];
  pick_t                             root_pick;

  always_comb begin
    for (int a = 0; a < NUM_LEAF; a++) begin
      for (int s = 0; s < NUM_SLOT; s++) begin
        leaf_req[a][s] = ARB_VALID[a][s] & service_i[ARB_MEMBER[a][s]];
      end
      leaf_pick[a]  = arb_pick(rot_i[a], leaf_req[a]);
      leaf_found[a] = leaf_pick[a].found;
      leaf_win[a]   = ARB_MEMBER[a][leaf_pick[a].slot];
      // advance every enabled leaf that saw a request, winner or not
      result_o.rotation[a] = (leaf_pick[a].found && rot_en_i[a]) ? rot_i[a] + 2'd1
                                                                   : rot_i[a];
    end
    root_pick = arb_pick(rot_i[NUM_ARB-1], leaf_found);
    result_o.rotation[NUM_ARB-1] = (root_pick.found && rot_en_i[NUM_ARB-1])
                                   ? rot_i[NUM_ARB-1] + 2'd1 : rot_i[NUM_ARB-1];
    result_o.offset = leaf_win[root_pick.slot];
  end

endmodule

`default_nettype wire

>>> design/rotating_priority_interrupt_controller_top.sv
// Top level of the two-level rotating priority interrupt controller.
// Each item is a register read or write or a source / sub-source event; the block takes one
// item per cycle while the result side is not stalled and returns exactly one result item for
// it. An item is captured in an input register, and a single combinational pass (event decode,
// up to four chained sub-group asserts, one arbiter tree evaluation) updates all state and
// loads the result register once the result side can take it. The irq and fiq fields carry the
// line levels after the item. There is no clearing pass after reset.
`default_nettype none

module rotating_priority_interrupt_controller_top import rpic_pkg::*; (
  input  wire        clk_i,
  input  wire        rst_ni,
  rpic_in_if.sink    in_i,
  rpic_out_if.source out_o
);

  // pipeline registers
  logic    in_vld_q;
  item_t   in_q;
  logic    out_vld_q;
  result_t out_q;
  logic    adv;

  // controller state
  logic [NUM_SRC-1:0] src_pend_q, src_pend_d;
  logic [NUM_SRC-1:0] fast_q, fast_b;
  logic [NUM_SRC-1:0] mask_q, mask_b;
  logic [NUM_SRC-1:0] svc_pend_q, svc_pend_b, svc_pend_d;
  logic [4:0]         svc_off_q, svc_off_d;
  logic [NUM_SUB-1:0] sub_pend_q, sub_pend_b, sub_pend_d;
  logic [NUM_SUB-1:0] sub_mask_q, sub_mask_b;
  logic [NUM_SRC-1:0] src_held_q, src_held_b;
  logic [NUM_SUB-1:0] sub_held_q, sub_held_b;
  rot_t               rot_q, rot_b, rot_d;
  logic [NUM_ARB-1:0] rot_en_q, rot_en_b;
  logic               irq_q, irq_d;
  logic               fiq_q, fiq_d;

  // evaluation
  logic [NUM_SRC-1:0]  src_pend_b;
  logic [NUM_SUB-1:0]  sub_svc;
  logic [NUM_SRC-1:0]  snap [NUM_EVAL];
  logic [NUM_EVAL-1:0] ev;
  logic [NUM_EVAL-1:0] fiq_hit;
  logic [NUM_EVAL-1:0] svc_hit;
  logic                ev_base;
  logic                sub_ev;
  logic                grp_hit;
  logic                sel_found;
  logic [2:0]          sel;
  logic                arb_go;
  logic [NUM_SRC-1:0]  arb_service;
  arb_result_t         arb_res;
  logic [3:0]          sub_idx;
  logic                sub_ok;
  logic [31:0]         wd;
  logic [31:0]         reg_rd;
  logic [31:0]         read_val;

  assign adv         = in_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready  = !in_vld_q || adv;
  assign out_o.valid = out_vld_q;
  assign out_o.data  = out_q;

  assign wd      = in_q.write_data;
  assign sub_idx = in_q.source[3:0];
  assign sub_ok  = in_q.source < 5'(NUM_SUB);

  // register read mux
  always_comb begin
    unique case (in_q.reg_index)
      REG_SRC_PEND:   reg_rd = src_pend_q;
      REG_FAST_MODE:  reg_rd = fast_q;
      REG_SRC_MASK:   reg_rd = mask_q;
      REG_PRIORITY: begin
        reg_rd = '0;
        reg_rd[NUM_ARB-1:0] = rot_en_q;
        for (int a = 0; a < NUM_ARB; a++) begin
          reg_rd[NUM_ARB + 2*a +: 2] = rot_q[a];
        end
      end
      REG_SVC_PEND:   reg_rd = svc_pend_q;
      REG_SVC_OFFSET: reg_rd = {27'd0, svc_off_q};
      REG_SUB_PEND:   reg_rd = {21'd0, sub_pend_q};
      REG_SUB_MASK:   reg_rd = {21'd0, sub_mask_q};
      default:        reg_rd = '1;
    endcase
  end

  // item decode, sub-group chain and arbitration request
  always_comb begin
    src_pend_b = src_pend_q;
    fast_b     = fast_q;
    mask_b     = mask_q;
    svc_pend_b = svc_pend_q;
    sub_pend_b = sub_pend_q;
    sub_mask_b = sub_mask_q;
    src_held_b = src_held_q;
    sub_held_b = sub_held_q;
    rot_b      = rot_q;
    rot_en_b   = rot_en_q;
    ev_base    = 1'b0;
    sub_ev     = 1'b0;
    read_val   = '0;

    unique case (in_q.op)
      OP_READ: read_val = reg_rd;
      OP_WRITE: begin
        unique case (in_q.reg_index)
          REG_SRC_PEND: begin
            src_pend_b = (src_pend_q & ~wd) | src_held_q;
            ev_base    = |(src_held_q & wd);
          end
          REG_FAST_MODE: begin
            fast_b  = wd & FAST_MODE_WMASK;
            ev_base = 1'b1;
          end
          REG_SRC_MASK: begin
            mask_b  = wd | MASK_FORCE;
            ev_base = 1'b1;
          end
          REG_PRIORITY: begin
            for (int a = 0; a < NUM_ARB; a++) begin
              rot_b[a] = wd[NUM_ARB + 2*a +: 2];
            end
            rot_en_b = wd[NUM_ARB-1:0];
            ev_base  = 1'b1;
          end
          REG_SVC_PEND: begin
            svc_pend_b = svc_pend_q & ~wd;
            ev_base    = 1'b1;
          end
          REG_SUB_PEND: begin
            sub_pend_b = (sub_pend_q & ~wd[NUM_SUB-1:0]) | sub_held_q;
            sub_ev     = |(sub_held_q & wd[NUM_SUB-1:0]);
          end
          REG_SUB_MASK: begin
            sub_mask_b = wd[NUM_SUB-1:0];
            sub_ev     = 1'b1;
          end
          default: ;
        endcase
      end
      OP_SRC_SET: begin
        if (!src_held_q[in_q.source]) begin
          src_held_b[in_q.source] = in_q.level;
          src_pend_b[in_q.source] = 1'b1;
          ev_base                 = 1'b1;
        end
      end
      OP_SRC_CLR: src_held_b[in_q.source] = 1'b0;
      OP_SUB_SET: begin
        if (sub_ok && !sub_held_q[sub_idx]) begin
          sub_held_b[sub_idx] = in_q.level;
          sub_pend_b[sub_idx] = 1'b1;
          sub_ev              = 1'b1;
        end
      end
      OP_SUB_CLR: begin
        if (sub_ok) begin
          sub_held_b[sub_idx] = 1'b0;
        end
      end
      default: ;
    endcase

    // on a sub-source event, each group with an unmasked sub-source asserts its source as a held level
    sub_svc = sub_pend_b & ~sub_mask_b;
    snap[0] = src_pend_b;
    ev[0]   = ev_base;
    for (int g = 0; g < NUM_GROUP; g++) begin
      grp_hit     = |(sub_svc & SUB_GROUP[g]);
      ev[g+1]     = sub_ev && grp_hit && !src_held_b[GROUP_SRC[g]];
      snap[g+1]   = snap[g];
      if (ev[g+1]) begin
        snap[g+1][GROUP_SRC[g]] = 1'b1;
      end
      if (sub_ev) begin
        src_held_b[GROUP_SRC[g]] = grp_hit;
      end
    end
    sub_pend_d = sub_ev ? sub_held_b : sub_pend_b;
    src_pend_d = snap[NUM_EVAL-1];

    for (int k = 0; k < NUM_EVAL; k++) begin
      fiq_hit[k] = |(snap[k] & fast_b);
      svc_hit[k] = |(snap[k] & ~mask_b);
    end

    // only the first evaluation that sees an unmasked request can arbitrate
    sel_found = 1'b0;
    sel       = '0;
    for (int k = 0; k < NUM_EVAL; k++) begin
      if (!sel_found && ev[k] && svc_hit[k]) begin
        sel_found = 1'b1;
        sel       = 3'(k);
      end
    end
    arb_service = snap[sel] & ~mask_b;
    arb_go      = sel_found && !fiq_hit[sel] && (svc_pend_b == '0);
  end

  rpic_arb_tree u_arb_tree (
    .service_i (arb_service),
    .rot_i     (rot_b),
    .rot_en_i  (rot_en_b),
    .result_o  (arb_res)
  );

  // commit arbitration and line levels
  always_comb begin
    svc_pend_d = svc_pend_b;
    svc_off_d  = svc_off_q;
    rot_d      = rot_b;
    if (arb_go) begin
      svc_pend_d[arb_res.offset] = 1'b1;
      svc_off_d                  = arb_res.offset;
      rot_d                      = arb_res.rotation;
    end
    fiq_d = (|ev) ? |(ev & fiq_hit) : fiq_q;
    irq_d = (|(ev & ~fiq_hit)) ? |svc_pend_d : irq_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q   <= 1'b0;
      out_vld_q  <= 1'b0;
      src_pend_q <= '0;
      fast_q     <= '0;
      mask_q     <= '1;
      svc_pend_q <= '0;
      svc_off_q  <= '0;
      sub_pend_q <= '0;
      sub_mask_q <= '1;
      src_held_q <= '0;
      sub_held_q <= '0;
      rot_q      <= '0;
      rot_en_q   <= '1;
      irq_q      <= 1'b0;
      fiq_q      <= 1'b0;
    end else begin
      if (in_i.ready) begin
        in_vld_q <= in_i.valid;
      end
      if (adv) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
      if (adv) begin
        src_pend_q <= src_pend_d;
        fast_q     <= fast_b;
        mask_q     <= mask_b;
        svc_pend_q <= svc_pend_d;
        svc_off_q  <= svc_off_d;
        sub_pend_q <= sub_pend_d;
        sub_mask_q <= sub_mask_b;
        src_held_q <= src_held_b;
        sub_held_q <= sub_held_b;
        rot_q      <= rot_d;
        rot_en_q   <= rot_en_b;
        irq_q      <= irq_d;
        fiq_q      <= fiq_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_q <= in_i.data;
    end
    if (adv) begin
      out_q <= '{read_data: read_val, irq_request: irq_d, fiq_request: fiq_d};
    end
  end

endmodule

`default_nettype wire

>>> design/rpic_checker.sv
// Port-level checks for the interrupt controller top level, bound into it.
`default_nettype none

module rpic_checker import rpic_pkg::*; (
  input wire     clk_i,
  input wire     rst_ni,
  input logic    in_valid_i,
  input logic    in_ready_i,
  input logic    out_valid_i,
  input logic    out_ready_i,
  input result_t out_data_i
);

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_i)
    else $error("result valid during reset");

  // a draining result side never holds off new items
  a_ready_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_i)
    else $error("input stalled while output drains");

  // every accepted item is followed by a valid result
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |-> ##2 out_valid_i)
    else $error("accepted item produced no result");

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(out_data_i)))
    else $error("stalled result changed");

endmodule

bind rotating_priority_interrupt_controller_top rpic_checker u_rpic_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);

`default_nettype wire
